// ===== rtl/ascii_number_string_parser_core_macros.svh =====
// Assertion macros shared by the parser RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASCII_NUMBER_STRING_PARSER_CORE_MACROS_SVH
`define ASCII_NUMBER_STRING_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define ANSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ANSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ansp_pkg.sv =====
`default_nettype none

package ansp_pkg;

  // Field and state widths.
  localparam int CharW  = 8;
  localparam int ValueW = 32;
  localparam int CountW = 8;
  localparam int DigitW = 4;

  // Default length limit on a string, prefix included.
  localparam int MaxLenDefault = 128;

  // Character codes of interest.
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;

  // Saturation point of the character counter.
  localparam logic [CountW-1:0] CountSat = '1;

  // Classification of one character.
  typedef struct packed {
    logic              is_nul;
    logic              is_zero;
    logic              is_x;
    logic              dec_ok;
    logic              hex_ok;
    logic [DigitW-1:0] digit;
  } char_class_t;

  // Result of one string.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     ok;
  } parse_res_t;

endpackage

`default_nettype wire

// ===== rtl/ascii_number_string_parser_core.sv =====
// A NUL passes from the input register into the output register, then transfers out.
// Throughput: one character per cycle while no NUL is held; the input register frees
// as the parse state updates.
// A NUL waits in the input register only while the output register is full and stalled.
// Reset (rst_n low, synchronous) clears both valids, the parse state and hex_only.
`default_nettype none

`include "ascii_number_string_parser_core_macros.svh"

module ascii_number_string_parser_core #(
  parameter int MAX_LEN = ansp_pkg::MaxLenDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ansp_pkg::CharW-1:0]          in_char_in,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ansp_pkg::ValueW-1:0]       out_parsed_value,
  output logic                                     out_parse_ok
);

  logic                         hex_only_r;
  logic                         v1_r;
  logic [ansp_pkg::CharW-1:0]   char_r;
  logic                         out_valid_r;
  ansp_pkg::parse_res_t         out_res_r;

  ansp_pkg::char_class_t        cls;
  ansp_pkg::parse_res_t         res;
  logic                         adv;
  logic                         step;
  logic                         in_xfer;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_only_r <= 1'b0;
    end else if (cfg_we) begin
      hex_only_r <= cfg_wdata;
    end
  end

  // Input register advances unless it holds a NUL that cannot reach the output.
  always_comb begin
    adv      = !cls.is_nul || !out_valid_r || !out_stall;
    step     = v1_r && adv;
    in_stall = v1_r && !adv;
    in_xfer  = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_xfer) begin
      v1_r <= 1'b1;
    end else if (step) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      char_r <= in_char_in;
    end
  end

  ansp_decode u_decode (
    .char_i  (char_r),
    .class_o (cls)
  );

  ansp_state #(
    .MAX_LEN (MAX_LEN)
  ) u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_i     (step),
    .class_i    (cls),
    .hex_only_i (hex_only_r),
    .res_o      (res)
  );

  // Output register; a NUL loads it when it is empty or as the previous result transfers out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && cls.is_nul) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && cls.is_nul) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = out_res_r.value;
  assign out_parse_ok     = out_res_r.ok;

  // A rejected string always reports a zero value.
  `ANSP_ASSERT_IMP(a_rej_zero, out_valid && !out_parse_ok, out_parsed_value == '0,
    "rejected result carries a non-zero value")

  // A NUL blocked by a full, stalled output must hold the input side.
  `ANSP_ASSERT_IMP(a_nul_hold, v1_r && cls.is_nul && out_valid && out_stall, in_stall,
    "NUL left the input register while the output was blocked")

  // A new result only follows a character held in the input register.
  `ANSP_ASSERT_IMP(a_res_src, $rose(out_valid), $past(v1_r),
    "result appeared without a character in the input register")

  // A retiring NUL always produces a result in the next cycle.
  `ANSP_ASSERT_NXT(a_nul_res, step && cls.is_nul, out_valid,
    "retired NUL produced no result")

endmodule

`default_nettype wire

// ===== rtl/ansp_decode.sv =====
`default_nettype none

module ansp_decode (
  input  wire logic [ansp_pkg::CharW-1:0] char_i,
  output ansp_pkg::char_class_t           class_o
);

  logic dec_ok;
  logic low_ok;
  logic up_ok;
  logic [ansp_pkg::CharW-1:0] off;

  // Range checks for the three digit groups.
  always_comb begin
    dec_ok = (char_i >= ansp_pkg::ChZero) && (char_i <= ansp_pkg::ChNine);
    low_ok = (char_i >= ansp_pkg::ChLowA) && (char_i <= ansp_pkg::ChLowF);
    up_ok  = (char_i >= ansp_pkg::ChUpA)  && (char_i <= ansp_pkg::ChUpF);
  end

  // Digit value; letters map onto ten to fifteen.
  always_comb begin
    if (low_ok) begin
      off = char_i - ansp_pkg::ChLowA + 8'd10;
    end else if (up_ok) begin
      off = char_i - ansp_pkg::ChUpA + 8'd10;
    end else begin
      off = char_i - ansp_pkg::ChZero;
    end
  end

  always_comb begin
    class_o.is_nul  = (char_i == ansp_pkg::ChNul);
    class_o.is_zero = (char_i == ansp_pkg::ChZero);
    class_o.is_x    = (char_i == ansp_pkg::ChLowX) || (char_i == ansp_pkg::ChUpX);
    class_o.dec_ok  = dec_ok;
    class_o.hex_ok  = dec_ok || low_ok || up_ok;
    class_o.digit   = off[ansp_pkg::DigitW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/ansp_state.sv =====
`default_nettype none

module ansp_state #(
  parameter int MAX_LEN = ansp_pkg::MaxLenDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_i,
  input  wire ansp_pkg::char_class_t class_i,
  input  wire logic                 hex_only_i,
  output ansp_pkg::parse_res_t      res_o
);

  localparam logic [ansp_pkg::CountW-1:0] MaxLenC = ansp_pkg::CountW'(MAX_LEN);

  logic [ansp_pkg::ValueW-1:0] acc_r, acc_nxt;
  logic [ansp_pkg::CountW-1:0] count_r, count_nxt;
  logic                        bad_r, bad_nxt;
  logic                        hex_r, hex_nxt;
  logic                        fz_r, fz_nxt;

  logic                        first;
  logic                        hex_cur;
  logic                        fz_cur;
  logic                        ok;
  logic [ansp_pkg::ValueW-1:0] digit_ext;

  // Result seen at the terminating NUL.
  always_comb begin
    ok          = !bad_r && (count_r <= MaxLenC);
    res_o.ok    = ok;
    res_o.value = ok ? acc_r : '0;
  end

  // Per-character update: shift-and-add on the accumulator.
  always_comb begin
    first     = (count_r == '0);
    hex_cur   = first ? hex_only_i : hex_r;
    fz_cur    = first ? class_i.is_zero : fz_r;
    digit_ext = ansp_pkg::ValueW'(class_i.digit);
    acc_nxt   = acc_r;
    count_nxt = count_r;
    bad_nxt   = bad_r;
    hex_nxt   = hex_cur;
    fz_nxt    = fz_cur;
    if (class_i.is_nul) begin
      acc_nxt   = '0;
      count_nxt = '0;
      bad_nxt   = 1'b0;
      hex_nxt   = 1'b0;
      fz_nxt    = 1'b0;
    end else begin
      if ((count_r == ansp_pkg::CountW'(1)) && fz_cur && !hex_cur && class_i.is_x) begin
        hex_nxt = 1'b1;
      end else if (hex_cur) begin
        if (class_i.hex_ok) begin
          acc_nxt = (acc_r << 4) + digit_ext;
        end else begin
          bad_nxt = 1'b1;
        end
      end else begin
        if (class_i.dec_ok) begin
          acc_nxt = (acc_r << 3) + (acc_r << 1) + digit_ext;
        end else begin
          bad_nxt = 1'b1;
        end
      end
      if (count_r != ansp_pkg::CountSat) begin
        count_nxt = count_r + ansp_pkg::CountW'(1);
      end
    end
  end

  // Per-string state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      count_r <= '0;
      bad_r   <= 1'b0;
      hex_r   <= 1'b0;
      fz_r    <= 1'b0;
    end else if (step_i) begin
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
      bad_r   <= bad_nxt;
      hex_r   <= hex_nxt;
      fz_r    <= fz_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== dv/ascii_number_string_parser_checker.sv =====
module ascii_number_string_parser_checker #(
  parameter int MAX_LEN = ansp_pkg::MaxLenDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_wdata,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [ansp_pkg::CharW-1:0]          in_char_in,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic signed [ansp_pkg::ValueW-1:0]  out_parsed_value,
  input  wire logic                                out_parse_ok,
  output int unsigned                              mismatch_count,
  output int unsigned                              results_pending
);

  // Parse results still owed by the block, oldest first.
  ansp_pkg::parse_res_t expected_results_q[$];

  // Predicted parse state of the string in progress.
  logic [ansp_pkg::ValueW-1:0] number_acc;
  logic [ansp_pkg::CountW-1:0] chars_seen;
  logic                        saw_bad_char;
  logic                        in_hex_mode;
  logic                        leading_zero;
  logic                        hex_only_q;
  int unsigned                 errors = 0;

  always @(posedge clk) begin : predict_and_compare
    ansp_pkg::parse_res_t          want;
    logic [ansp_pkg::DigitW:0]     nibble;
    logic [ansp_pkg::CharW-1:0]    ch;
    if (!rst_n) begin
      number_acc   = '0;
      chars_seen   = '0;
      saw_bad_char = 1'b0;
      in_hex_mode  = 1'b0;
      leading_zero = 1'b0;
      hex_only_q   = 1'b0;
      expected_results_q.delete();
    end else begin
      if (cfg_we) begin
        hex_only_q = cfg_wdata;
      end

      // A result transfer is compared with the oldest outstanding expectation.
      if (out_valid && !out_stall) begin
        if (expected_results_q.size() == 0) begin
          $error("Result transfer with nothing expected: parsed_value %0d, parse_ok %0b",
                 out_parsed_value, out_parse_ok);
          errors++;
        end else begin
          want = expected_results_q.pop_front();
          if (out_parsed_value !== want.value) begin
            $error("parsed_value: expected %0d, actual %0d", want.value, out_parsed_value);
            errors++;
          end
          if (out_parse_ok !== want.ok) begin
            $error("parse_ok: expected %0b, actual %0b", want.ok, out_parse_ok);
            errors++;
          end
        end
      end

      // A character transfer advances the parse; a NUL closes the string.
      if (in_valid && !in_stall) begin
        ch = in_char_in;
        if (ch == ansp_pkg::ChNul) begin
          want.ok    = !saw_bad_char && (chars_seen <= MAX_LEN);
          want.value = want.ok ? number_acc : '0;
          expected_results_q.push_back(want);
          number_acc   = '0;
          chars_seen   = '0;
          saw_bad_char = 1'b0;
          in_hex_mode  = 1'b0;
          leading_zero = 1'b0;
        end else begin
          // The mode is fixed by the register as the string opens.
          if (chars_seen == 0) begin
            in_hex_mode  = hex_only_q;
            leading_zero = (ch == ansp_pkg::ChZero);
          end

          // Hex digit value, with the top bit set for anything else.
          if (ch >= ansp_pkg::ChZero && ch <= ansp_pkg::ChNine) begin
            nibble = 5'(ch - ansp_pkg::ChZero);
          end else if (ch >= ansp_pkg::ChLowA && ch <= ansp_pkg::ChLowF) begin
            nibble = 5'(ch - ansp_pkg::ChLowA + 8'd10);
          end else if (ch >= ansp_pkg::ChUpA && ch <= ansp_pkg::ChUpF) begin
            nibble = 5'(ch - ansp_pkg::ChUpA + 8'd10);
          end else begin
            nibble = 5'd16;
          end

          if (chars_seen == 1 && leading_zero && !in_hex_mode &&
              (ch == ansp_pkg::ChLowX || ch == ansp_pkg::ChUpX)) begin
            in_hex_mode = 1'b1;
          end else if (in_hex_mode) begin
            if (nibble[ansp_pkg::DigitW]) begin
              saw_bad_char = 1'b1;
            end else begin
              number_acc = {number_acc[ansp_pkg::ValueW-ansp_pkg::DigitW-1:0],
                            nibble[ansp_pkg::DigitW-1:0]};
            end
          end else begin
            if (ch < ansp_pkg::ChZero || ch > ansp_pkg::ChNine) begin
              saw_bad_char = 1'b1;
            end else begin
              number_acc = number_acc * 32'd10 + 32'(ch - ansp_pkg::ChZero);
            end
          end

          if (chars_seen != ansp_pkg::CountSat) begin
            chars_seen++;
          end
        end
      end
    end
    mismatch_count  <= errors;
    results_pending <= expected_results_q.size();
  end

endmodule

// ===== dv/tb_ascii_number_string_parser_core.sv =====
module tb_ascii_number_string_parser_core;

  // Cycles without any transfer before the run is abandoned.
  localparam int QuietLimit = 2000;
  // Random characters sent in each phase of the random part.
  localparam int PhaseChars = 24;

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               cfg_we     = 1'b0;
  logic                               cfg_wdata  = 1'b0;
  logic                               in_valid   = 1'b0;
  logic [ansp_pkg::CharW-1:0]         in_char_in = '0;
  logic                               out_stall  = 1'b0;
  logic                               in_stall;
  logic                               out_valid;
  logic signed [ansp_pkg::ValueW-1:0] out_parsed_value;
  logic                               out_parse_ok;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned chars_sent     = 0;
  int unsigned quiet_cycles   = 0;
  logic        hex_only_cfg   = 1'b0;

  always #5 clk = ~clk;

  ascii_number_string_parser_core DUT (.*);

  ascii_number_string_parser_checker checker_i (.*);

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog on cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one character, with random idle cycles first, and waits for its transfer.
  task automatic send_char(input logic [ansp_pkg::CharW-1:0] ch);
    logic took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= ch;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    chars_sent++;
  endtask

  // Sends a whole string followed by its terminating NUL.
  task automatic send_string(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_char(text[i]);
    end
    send_char(ansp_pkg::ChNul);
  endtask

  // Stops sending and lets every owed result arrive.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes the mode register once the block has gone quiet.
  task automatic set_hex_only(input logic val);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    hex_only_cfg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ansp_pkg::CharW-1:0] pick_digit(input logic hex);
    string digits;
    if (hex) begin
      digits = "0123456789abcdefABCDEF";
    end else begin
      digits = "0123456789";
    end
    return digits[$urandom_range(0, digits.len() - 1)];
  endfunction

  // Mostly well-formed numbers with random digits; some noise, some corruption,
  // and the odd string around or far beyond the length limit.
  task automatic send_random_string();
    string       text;
    int unsigned len;
    int unsigned pick;
    text = "";
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(250, 260) : $urandom_range(126, 130);
      repeat (len) text = $sformatf("%s%c", text, pick_digit(hex_only_cfg));
    end else if (pick < 16) begin
      repeat ($urandom_range(0, 6)) text = $sformatf("%s%c", text, 8'($urandom_range(1, 255)));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          repeat ($urandom_range(0, 11)) text = $sformatf("%s%c", text, pick_digit(1'b0));
        end
        1: begin
          if ($urandom_range(0, 1) != 0) begin
            text = "0x";
          end else begin
            text = "0X";
          end
          repeat ($urandom_range(0, 9)) text = $sformatf("%s%c", text, pick_digit(1'b1));
        end
        default: begin
          repeat ($urandom_range(1, 9)) text = $sformatf("%s%c", text, pick_digit(1'b1));
        end
      endcase
      if (text.len() > 0 && $urandom_range(0, 7) == 0) begin
        text[$urandom_range(0, text.len() - 1)] = 8'($urandom_range(1, 255));
      end
    end
    send_string(text);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings in auto mode: empty, bare prefix, both prefix cases,
    // and a character just above the decimal digits.
    set_hex_only(1'b0);
    send_string("");
    send_string("0x");
    send_string("0XfF");
    send_string("9:");

    // Directed strings in hex-only mode: the prefix is rejected there, a letter
    // just past F, the top character code and one just below the digits.
    set_hex_only(1'b1);
    send_string("0x");
    send_string("aG9");
    send_string($sformatf("%c", 8'hFF));
    send_string("/");

    // Random phases: each idling pattern once per register setting.
    for (int phase = 0; phase < 8; phase++) begin
      set_hex_only(phase[0]);
      case (phase / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 68; end
        default: begin send_idle_pct = 37; recv_stall_pct <= 37; end
      endcase
      chars_sent = 0;
      while (chars_sent < PhaseChars) begin
        send_random_string();
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
